@@ sv/dpts_pkg.sv @@
package dpts_pkg;

    typedef enum logic [2:0] {
        POL_FIXED_A   = 3'd0,
        POL_FIXED_B   = 3'd1,
        POL_ALTERNATE = 3'd2,
        POL_PROB      = 3'd3,
        POL_DELAY     = 3'd4,
        POL_QUEUE     = 3'd5,
        POL_RANDOM    = 3'd6
    } policy_t;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [2:0] REG_POLICY    = 3'd0;
    localparam logic [2:0] REG_MULTI     = 3'd1;
    localparam logic [2:0] REG_DUAL      = 3'd2;
    localparam logic [2:0] REG_DUPLICATE = 3'd3;
    localparam logic [2:0] REG_CELL_A    = 3'd4;
    localparam logic [2:0] REG_CELL_B    = 3'd5;
    localparam logic [2:0] REG_LOCAL     = 3'd6;
    localparam logic [2:0] REG_SEQ_MAX   = 3'd7;

    typedef struct packed {
        policy_t      split_policy;
        logic         multi_connection_on;
        logic         dual_conn_mode;
        logic         duplicate_on;
        logic [15:0]  cell_a_id;
        logic [15:0]  cell_b_id;
        logic [15:0]  local_cell_id;
        logic [11:0]  seq_max;
    } cfg_t;

    typedef struct packed {
        logic         to_local;
        logic [15:0]  dest_cell;
        logic [11:0]  seq_number;
        logic         last;
    } result_t;

    // delay average, Q.8 of raw/10000; bounded by 0.0256 * 2^32 < 2^27
    localparam int DLY_W = 27;
    localparam logic [16:0] DLY_OLD_W = 17'd90000;
    // N / 100000 == (N >> 5) / 3125; ceil(2^51 / 3125) is exact for 39-bit dividends
    localparam int DLY_Q_SHIFT = 51;
    localparam logic [39:0] DLY_RECIP = 40'((64'd1 << DLY_Q_SHIFT) / 64'd3125 + 64'd1);

    localparam logic [6:0]  WARMUP_LEN  = 7'd100;
    localparam logic [9:0]  SHARE_FULL  = 10'd1000;
    localparam logic [9:0]  SHARE_RESET = 10'd500;
    localparam logic [15:0] LFSR_TAPS   = 16'hB400;
    localparam logic [15:0] LFSR_SEED   = 16'hACE1;
    localparam logic [25:0] PROB_SCALE  = 26'd1000;
    localparam logic [22:0] RAND_SCALE  = 23'd100;
    localparam logic [22:0] RAND_LIMIT  = 23'd327680;

endpackage

@@ sv/dpts_dly_avg.sv @@
module dpts_dly_avg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 head_delay,
    output logic [dpts_pkg::DLY_W-1:0]  avg,
    output logic                        busy
);

    logic                        v1_reg, v2_reg, v3_reg;
    logic [31:0]                 d_reg;
    logic [38:0]                 m_reg, m_next;
    logic [39:0]                 pp_ll_reg, pp_lh_reg;
    logic [38:0]                 pp_hl_reg, pp_hh_reg;
    logic [dpts_pkg::DLY_W-1:0]  avg_reg, avg_next;
    logic [43:0]                 num;
    logic [79:0]                 sum;

    // weighted numerator, pre-divided by 32
    always_comb
    begin
        num    = 44'({d_reg, 8'd0}) + 44'(avg_reg) * 44'(dpts_pkg::DLY_OLD_W);
        m_next = num[43:5];
    end

    // reassemble the partial products of the reciprocal multiply
    always_comb
    begin
        sum = 80'(pp_ll_reg)
            + (80'(pp_lh_reg) << 20)
            + (80'(pp_hl_reg) << 20)
            + (80'(pp_hh_reg) << 40);
        avg_next = sum[dpts_pkg::DLY_Q_SHIFT +: dpts_pkg::DLY_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            avg_reg <= '0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg)
            begin
                avg_reg <= avg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg <= head_delay;
        end
        if (v1_reg)
        begin
            m_reg <= m_next;
        end
        if (v2_reg)
        begin
            pp_ll_reg <= 40'(m_reg[19:0])  * 40'(dpts_pkg::DLY_RECIP[19:0]);
            pp_lh_reg <= 40'(m_reg[19:0])  * 40'(dpts_pkg::DLY_RECIP[39:20]);
            pp_hl_reg <= 39'(m_reg[38:20]) * 39'(dpts_pkg::DLY_RECIP[19:0]);
            pp_hh_reg <= 39'(m_reg[38:20]) * 39'(dpts_pkg::DLY_RECIP[39:20]);
        end
    end

    assign avg  = avg_reg;
    assign busy = v1_reg | v2_reg | v3_reg;

endmodule

@@ sv/dpts_route.sv @@
module dpts_route (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic                        is_report,
    input  dpts_pkg::cfg_t              cfg,
    input  logic [dpts_pkg::DLY_W-1:0]  delay_a,
    input  logic [dpts_pkg::DLY_W-1:0]  delay_b,
    input  logic [32:0]                 queue_a,
    input  logic [32:0]                 queue_b,
    output logic [1:0]                  n_results,
    output dpts_pkg::result_t           res0,
    output dpts_pkg::result_t           res1
);

    logic [11:0]  next_seq_reg, next_seq_next;
    logic [6:0]   warmup_reg;
    logic         tie_reg;
    logic [9:0]   share_reg, share_adj, share_new;
    logic [15:0]  lfsr_reg, lfsr_step;
    logic [12:0]  seq_inc;
    logic         d_any;
    logic         pick_b, tie_flip, use_lfsr, share_upd;
    logic         choose_used, warm_inc;
    logic [15:0]  cell_b_eff, chosen;

    always_comb
    begin
        lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ dpts_pkg::LFSR_TAPS) : (lfsr_reg >> 1);
        d_any     = (delay_a != '0) || (delay_b != '0);
        if (delay_a > delay_b)
        begin
            share_adj = (share_reg != 10'd0) ? share_reg - 10'd1 : share_reg;
        end
        else
        begin
            share_adj = (share_reg < dpts_pkg::SHARE_FULL) ? share_reg + 10'd1
                                                           : dpts_pkg::SHARE_FULL;
        end
        share_new = d_any ? share_adj : share_reg;
        seq_inc   = {1'b0, next_seq_reg} + 13'd1;
        next_seq_next = (seq_inc > {1'b0, cfg.seq_max}) ? 12'd0 : seq_inc[11:0];
    end

    // policy decision
    always_comb
    begin
        pick_b    = 1'b0;
        tie_flip  = 1'b0;
        use_lfsr  = 1'b0;
        share_upd = 1'b0;
        unique case (cfg.split_policy)
            dpts_pkg::POL_FIXED_A: pick_b = 1'b0;
            dpts_pkg::POL_FIXED_B: pick_b = 1'b1;
            dpts_pkg::POL_ALTERNATE:
            begin
                pick_b   = ~tie_reg;
                tie_flip = 1'b1;
            end
            dpts_pkg::POL_PROB:
            begin
                use_lfsr  = 1'b1;
                share_upd = d_any;
                pick_b    = !((26'(lfsr_step) * dpts_pkg::PROB_SCALE) < {share_new, 16'd0});
            end
            dpts_pkg::POL_DELAY:
            begin
                priority if (delay_a > delay_b)
                    pick_b = 1'b1;
                else if (delay_b > delay_a)
                    pick_b = 1'b0;
                else
                begin
                    pick_b   = tie_reg;
                    tie_flip = 1'b1;
                end
            end
            dpts_pkg::POL_QUEUE:
            begin
                priority if (queue_a > queue_b)
                    pick_b = 1'b1;
                else if (queue_b > queue_a)
                    pick_b = 1'b0;
                else
                begin
                    pick_b   = tie_reg;
                    tie_flip = 1'b1;
                end
            end
            dpts_pkg::POL_RANDOM:
            begin
                use_lfsr = 1'b1;
                pick_b   = !((23'(lfsr_step) * dpts_pkg::RAND_SCALE) > dpts_pkg::RAND_LIMIT);
            end
            default: pick_b = 1'b0;
        endcase
    end

    // route selection
    always_comb
    begin
        cell_b_eff  = cfg.dual_conn_mode ? cfg.local_cell_id : cfg.cell_b_id;
        chosen      = pick_b ? cell_b_eff : cfg.cell_a_id;
        choose_used = 1'b0;
        warm_inc    = 1'b0;
        n_results   = 2'd1;
        res0 = '{to_local: 1'b1, dest_cell: cfg.local_cell_id,
                 seq_number: next_seq_reg, last: 1'b1};
        res1 = '{to_local: 1'b0, dest_cell: cell_b_eff,
                 seq_number: next_seq_reg, last: 1'b1};
        priority if (!cfg.multi_connection_on)
        begin
            n_results = 2'd1;
        end
        else if (cfg.dual_conn_mode)
        begin
            choose_used = 1'b1;
            if (chosen != cfg.local_cell_id)
            begin
                res0.to_local  = 1'b0;
                res0.dest_cell = cfg.cell_a_id;
            end
        end
        else if (warmup_reg < dpts_pkg::WARMUP_LEN)
        begin
            warm_inc       = 1'b1;
            res0.to_local  = 1'b0;
            res0.dest_cell = warmup_reg[0] ? cfg.cell_a_id : cell_b_eff;
        end
        else if (cfg.duplicate_on)
        begin
            if (cfg.cell_a_id != cfg.local_cell_id && cell_b_eff != cfg.local_cell_id)
            begin
                res0.to_local  = 1'b0;
                res0.dest_cell = cfg.cell_a_id;
                res0.last      = 1'b0;
                n_results      = 2'd2;
            end
        end
        else
        begin
            choose_used = 1'b1;
            if (chosen != cfg.local_cell_id)
            begin
                res0.to_local  = 1'b0;
                res0.dest_cell = chosen;
            end
        end
        if (is_report)
        begin
            n_results = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq_reg <= '0;
            warmup_reg   <= '0;
            tie_reg      <= 1'b0;
            share_reg    <= dpts_pkg::SHARE_RESET;
            lfsr_reg     <= dpts_pkg::LFSR_SEED;
        end
        else if (fire)
        begin
            next_seq_reg <= next_seq_next;
            if (warm_inc)
            begin
                warmup_reg <= warmup_reg + 7'd1;
            end
            if (choose_used && tie_flip)
            begin
                tie_reg <= ~tie_reg;
            end
            if (choose_used && use_lfsr)
            begin
                lfsr_reg <= lfsr_step;
            end
            if (choose_used && share_upd)
            begin
                share_reg <= share_adj;
            end
        end
    end

endmodule

@@ sv/dual_path_traffic_splitter.sv @@
// Dual-path traffic splitter: routes packets over a local path and two cell paths.
// Item channel (item_valid / item_stall): operation 0 is a packet to route,
// operation 1 is a queue report that updates a path's queue size and delay average.
// Result channel (result_valid / result_stall): one result per packet, two in
// duplicate mode when neither cell is local (path A first, last set on path B only).
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): ready is always high;
// write only while the block is idle.
// An accepted packet is routed combinationally from the item register into the result
// buffer. Throughput: one packet per cycle while results drain and no delay update is
// in flight, limited by the combinational route stage between the item register and
// the two-entry result buffer. A duplicated packet enters only an empty buffer, so each
// pair drains before the next is taken. A queue report leaves the item register once no
// delay update is in flight, then holds the next item there while the delay average
// runs through its three-stage pipeline. Reset: configuration returns to its defaults,
// counters and path statistics clear, LFSR and share load their reset values at once;
// no clearing pass. When the receiver stalls, results collect in the two-entry buffer
// and item_stall rises once it cannot take the next item's results.
module dual_path_traffic_splitter (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  logic         operation,
    input  logic [15:0]  report_cell,
    input  logic [31:0]  pending_bytes,
    input  logic [31:0]  sent_bytes,
    input  logic [31:0]  head_delay,
    output logic         result_valid,
    input  logic         result_stall,
    output logic         to_local,
    output logic [15:0]  dest_cell,
    output logic [11:0]  seq_number,
    output logic         last,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    dpts_pkg::cfg_t     cfg_reg;
    logic               itm_valid_reg;
    logic               itm_op_reg;
    logic [15:0]        itm_cell_reg;
    logic [31:0]        itm_pend_reg;
    logic [31:0]        itm_sent_reg;
    logic [31:0]        itm_delay_reg;
    logic [32:0]        queue_reg [2];
    dpts_pkg::result_t  fifo_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               accept, advance, pop, is_report, fire;
    logic [1:0]         n_results, push_n;
    logic [2:0]         fill;
    logic [1:0]         match;
    logic [1:0]         dly_start;
    logic               busy_a, busy_b, dly_busy;
    logic [15:0]        cell_b_eff;
    logic [dpts_pkg::DLY_W-1:0] delay_a, delay_b;
    dpts_pkg::result_t  res0, res1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.split_policy        <= dpts_pkg::POL_ALTERNATE;
            cfg_reg.multi_connection_on <= 1'b0;
            cfg_reg.dual_conn_mode      <= 1'b0;
            cfg_reg.duplicate_on        <= 1'b0;
            cfg_reg.cell_a_id           <= '0;
            cfg_reg.cell_b_id           <= '0;
            cfg_reg.local_cell_id       <= '0;
            cfg_reg.seq_max             <= 12'd4095;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dpts_pkg::REG_POLICY:
                    cfg_reg.split_policy <= dpts_pkg::policy_t'(cfg_data[2:0]);
                dpts_pkg::REG_MULTI:     cfg_reg.multi_connection_on <= cfg_data[0];
                dpts_pkg::REG_DUAL:      cfg_reg.dual_conn_mode <= cfg_data[0];
                dpts_pkg::REG_DUPLICATE: cfg_reg.duplicate_on <= cfg_data[0];
                dpts_pkg::REG_CELL_A:    cfg_reg.cell_a_id <= cfg_data;
                dpts_pkg::REG_CELL_B:    cfg_reg.cell_b_id <= cfg_data;
                dpts_pkg::REG_LOCAL:     cfg_reg.local_cell_id <= cfg_data;
                dpts_pkg::REG_SEQ_MAX:   cfg_reg.seq_max <= cfg_data[11:0];
            endcase
        end
    end

    // hand-off from the item register to the route stage
    always_comb
    begin
        is_report  = (itm_op_reg == dpts_pkg::OP_REPORT);
        dly_busy   = busy_a | busy_b;
        fill       = {1'b0, cnt_reg} + {1'b0, n_results};
        advance    = itm_valid_reg && !dly_busy && (fill <= 3'd2);
        fire       = advance && !is_report;
        item_stall = itm_valid_reg && !advance;
        accept     = item_valid && !item_stall;
        cell_b_eff = cfg_reg.dual_conn_mode ? cfg_reg.local_cell_id : cfg_reg.cell_b_id;
        match[0]   = (cfg_reg.cell_a_id == itm_cell_reg);
        match[1]   = (cell_b_eff == itm_cell_reg);
        dly_start  = (advance && is_report) ? match : 2'b00;
        push_n     = advance ? n_results : 2'd0;
        pop        = (cnt_reg != 2'd0) && !result_stall;
        cnt_next   = cnt_reg + push_n - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itm_valid_reg <= 1'b0;
            queue_reg[0]  <= '0;
            queue_reg[1]  <= '0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (accept)
                itm_valid_reg <= 1'b1;
            else if (advance)
                itm_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                if (dly_start[i])
                    queue_reg[i] <= 33'(itm_pend_reg) + 33'(itm_sent_reg);
            end
            wr_ptr_reg <= wr_ptr_reg ^ push_n[0];
            rd_ptr_reg <= rd_ptr_reg ^ pop;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            itm_op_reg    <= operation;
            itm_cell_reg  <= report_cell;
            itm_pend_reg  <= pending_bytes;
            itm_sent_reg  <= sent_bytes;
            itm_delay_reg <= head_delay;
        end
        // a pair always lands in an empty buffer, so both slots are free
        if (push_n != 2'd0)
            fifo_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            fifo_reg[~wr_ptr_reg] <= res1;
    end

    dpts_dly_avg u_dly_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dly_start[0]),
        .head_delay (itm_delay_reg),
        .avg        (delay_a),
        .busy       (busy_a)
    );

    dpts_dly_avg u_dly_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dly_start[1]),
        .head_delay (itm_delay_reg),
        .avg        (delay_b),
        .busy       (busy_b)
    );

    dpts_route u_route (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .is_report (is_report),
        .cfg       (cfg_reg),
        .delay_a   (delay_a),
        .delay_b   (delay_b),
        .queue_a   (queue_reg[0]),
        .queue_b   (queue_reg[1]),
        .n_results (n_results),
        .res0      (res0),
        .res1      (res1)
    );

    assign result_valid = (cnt_reg != 2'd0);
    assign to_local     = fifo_reg[rd_ptr_reg].to_local;
    assign dest_cell    = fifo_reg[rd_ptr_reg].dest_cell;
    assign seq_number   = fifo_reg[rd_ptr_reg].seq_number;
    assign last         = fifo_reg[rd_ptr_reg].last;

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("result buffer overfilled");

    assert property (@(posedge clk) disable iff (!rst_n) fire |=> result_valid)
        else $error("routed packet left no result");

    assert property (@(posedge clk) disable iff (!rst_n) (dly_start != 2'b00) |=> dly_busy)
        else $error("delay update did not start");

    assert property (@(posedge clk) disable iff (!rst_n) dly_busy |-> !advance)
        else $error("item passed while delay average in flight");

endmodule
